[hdl/mhbf_pkg.sv]
package mhbf_pkg;

    localparam int BEAD_COUNT_DEF = 4096;

    // request codes
    localparam logic [1:0] REQ_LOAD = 2'd0;
    localparam logic [1:0] REQ_BOND = 2'd1;
    localparam logic [1:0] REQ_READ = 2'd2;

    // status codes
    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_ZERO = 2'd1;
    localparam logic [1:0] STAT_SAT  = 2'd2;

    localparam logic [16:0] ONE_Q16     = 17'h1_0000;
    localparam logic [47:0] LIM48_POS   = 48'h7FFF_FFFF_FFFF;
    localparam logic [47:0] LIM48_NEG   = 48'h8000_0000_0000;
    localparam logic [62:0] MAX63       = 63'h7FFF_FFFF_FFFF_FFFF;

    typedef enum logic [4:0] {
        S_IDLE,
        S_NOP,
        S_LOAD,
        S_FRD,
        S_FRD_WAIT,
        S_POS,
        S_MID,
        S_MID_DONE,
        S_SQ,
        S_SQ_DONE,
        S_SQRT,
        S_TEN,
        S_KD_DONE,
        S_E1,
        S_E2,
        S_NUM,
        S_NUM_DONE,
        S_W,
        S_DIV_INIT,
        S_DIV,
        S_SHARE,
        S_ACC,
        S_MUL
    } state_t;

endpackage

[hdl/midpoint_harmonic_bond_force.sv]
// Harmonic bond force engine over a bead store of BEAD_COUNT entries. Pulse start with busy low
// to hand in one item; exactly one result comes back later on the result ports for a single
// cycle, flagged by done, and it must be captured then since nothing holds it. For a coordinate
// load or request type three, done is set from state S_LOAD or S_NOP; for a force read it is
// set from S_FRD_WAIT, after S_FRD. One sequencer drives a shared 32x32 multiplier (8 partial
// products), a 37-step square root and a 128-step restoring divider, and the twelve force
// shares (three axes times four beads), each a multiply, a divide and a read-modify-write
// of the force memory, fill most of a bond's run time.
// Bead positions and forces sit in two single-port synchronous memories; unwritten entries
// read as garbage, so every bead must be loaded before a bond or a read touches it.
module midpoint_harmonic_bond_force #(
    parameter int BEAD_COUNT = mhbf_pkg::BEAD_COUNT_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    output logic               done,
    input  logic [1:0]         req_type,
    input  logic [11:0]        bead_a,
    input  logic [11:0]        bead_b,
    input  logic [11:0]        bead_c,
    input  logic [11:0]        bead_d,
    input  logic signed [31:0] coord_x,
    input  logic signed [31:0] coord_y,
    input  logic signed [31:0] coord_z,
    input  logic [16:0]        pos_first,
    input  logic [16:0]        pos_second,
    input  logic [31:0]        stiffness,
    input  logic [30:0]        rest_length,
    output logic [62:0]        energy,
    output logic signed [47:0] tension,
    output logic signed [47:0] force_x,
    output logic signed [47:0] force_y,
    output logic signed [47:0] force_z,
    output logic [1:0]         status
);

    localparam int IW = (BEAD_COUNT > 1) ? $clog2(BEAD_COUNT) : 1;

    // bead index folded into the store by long division against shifted copies of the depth
    function automatic logic [IW-1:0] bead_mod(input logic [11:0] v);
        logic [16:0] r;
        r = 17'(v);
        for (int s = 9; s >= 0; s--) begin
            if (32'(r) >= 32'(BEAD_COUNT << s)) begin
                r = r - 17'(BEAD_COUNT << s);
            end
        end
        return r[IW-1:0];
    endfunction

    // memories: position word {z,y,x} of 32 bits, force word {z,y,x} of 48 bits
    logic [95:0]  pos_mem [BEAD_COUNT];
    logic [143:0] force_mem [BEAD_COUNT];
    logic [95:0]  pos_rd_reg;
    logic [143:0] frd_reg;

    mhbf_pkg::state_t state_reg, state_next, ret_reg, ret_next;

    logic [6:0]   cnt_reg, cnt_next;
    logic [IW-1:0] idx_reg [4];
    logic [IW-1:0] idx_next [4];
    logic [16:0]  f1_reg, f1_next, f2_reg, f2_next;
    logic [31:0]  k_reg, k_next;
    logic [30:0]  rl_reg, rl_next;
    logic [95:0]  coord_reg, coord_next;
    logic [95:0]  p_lo_reg [2];
    logic [95:0]  p_lo_next [2];
    logic [95:0]  p_hi_reg [2];
    logic [95:0]  p_hi_next [2];
    logic [33:0]  m_reg [3];
    logic [33:0]  m_next [3];
    logic [33:0]  v1_reg, v1_next;
    logic [1:0]   ax_reg, ax_next, bd_reg, bd_next;
    logic         seg_reg, seg_next;
    logic [67:0]  s_reg, s_next;
    logic [73:0]  sq_reg, sq_next;
    logic [38:0]  rem_reg, rem_next;
    logic [36:0]  root_reg, root_next;
    logic [36:0]  d_reg, d_next, ad_reg, ad_next;
    logic         neg_reg, neg_next, sat_reg, sat_next;
    logic [68:0]  kd_reg, kd_next;
    logic [47:0]  ten_reg, ten_next;
    logic [62:0]  e_reg, e_next;
    logic [101:0] num_reg, num_next;
    logic [127:0] div_n_reg, div_n_next;
    logic [47:0]  share_reg, share_next;
    logic [127:0] mul_a_reg, mul_a_next;
    logic [63:0]  mul_b_reg, mul_b_next;
    logic [191:0] acc_reg, acc_next;
    logic [63:0]  prod_reg;

    // result registers
    logic         done_reg, done_next;
    logic [62:0]  energy_reg, energy_next;
    logic [47:0]  tension_reg, tension_next;
    logic [47:0]  fx_reg, fx_next, fy_reg, fy_next, fz_reg, fz_next;
    logic [1:0]   status_reg, status_next;

    // multiplier launch and memory controls
    logic         go_mul;
    logic [127:0] go_a;
    logic [63:0]  go_b;
    mhbf_pkg::state_t go_ret;
    logic         pos_we, force_we;
    logic [143:0] force_wdata;
    logic [1:0]   sel;
    logic [IW-1:0] idx_sel;

    // datapath
    logic [95:0]  p1w, p2w;
    logic [31:0]  p1, p2;
    logic [32:0]  diff, diff_mag, t_mid;
    logic [16:0]  f_seg, f_bd, w_bd;
    logic [33:0]  vmid, m_cur, m_abs;
    logic [67:0]  s_sum;
    logic [38:0]  rem2, trial, drem2, d39;
    logic         sq_ge, dv_ge;
    logic [37:0]  dl, dl_abs;
    logic [52:0]  ten_mag;
    logic [47:0]  ten_lim, ten_val, ten_out;
    logic         ten_over, e_over;
    logic [62:0]  e_val;
    logic [95:0]  qs;
    logic         sh_sign, sh_over;
    logic [47:0]  sh_lim, sh_val, sh_out;
    logic [47:0]  lane, new_lane;
    logic [48:0]  sum49;
    logic         acc_ovf;
    logic [2:0]   mul_pc, mul_sh;
    logic [31:0]  a_limb, b_limb;
    logic [191:0] acc_add;

    assign busy    = (state_reg != mhbf_pkg::S_IDLE);
    assign done    = done_reg;
    assign energy  = energy_reg;
    assign tension = tension_reg;
    assign force_x = fx_reg;
    assign force_y = fy_reg;
    assign force_z = fz_reg;
    assign status  = status_reg;

    // one address for both memories: bead number during position fetch, share bead during
    // force update, first bead otherwise
    always_comb begin
        if (state_reg == mhbf_pkg::S_POS) begin
            sel = cnt_reg[1:0];
        end else if (state_reg == mhbf_pkg::S_SHARE || state_reg == mhbf_pkg::S_ACC) begin
            sel = bd_reg;
        end else begin
            sel = 2'd0;
        end
    end
    assign idx_sel = idx_reg[sel];

    // midpoint on one axis of one segment
    assign p1w      = p_lo_reg[seg_reg];
    assign p2w      = p_hi_reg[seg_reg];
    assign p1       = p1w[{ax_reg, 5'd0} +: 32];
    assign p2       = p2w[{ax_reg, 5'd0} +: 32];
    assign diff     = {p2[31], p2} - {p1[31], p1};
    assign diff_mag = diff[32] ? (33'd0 - diff) : diff;
    assign f_seg    = seg_reg ? f2_reg : f1_reg;
    assign t_mid    = acc_reg[48:16];
    assign vmid     = {{2{p1[31]}}, p1}
                    + (diff[32] ? (34'd0 - {1'b0, t_mid}) : {1'b0, t_mid});

    assign m_cur = m_reg[ax_reg];
    assign m_abs = m_cur[33] ? (34'd0 - m_cur) : m_cur;
    assign s_sum = s_reg + acc_reg[67:0];

    // square root, two radicand bits a step
    assign rem2  = {rem_reg[36:0], sq_reg[73:72]};
    assign trial = {root_reg, 2'b01};
    assign sq_ge = (rem2 >= trial);

    // restoring divide, one quotient bit a step
    assign drem2 = {rem_reg[37:0], div_n_reg[127]};
    assign d39   = {2'd0, d_reg};
    assign dv_ge = (drem2 >= d39);

    // stretch and tension
    assign dl       = {1'b0, d_reg} - {7'd0, rl_reg};
    assign dl_abs   = dl[37] ? (38'd0 - dl) : dl;
    assign ten_mag  = acc_reg[68:16];
    assign ten_lim  = neg_reg ? mhbf_pkg::LIM48_NEG : mhbf_pkg::LIM48_POS;
    assign ten_over = (ten_mag > {5'd0, ten_lim});
    assign ten_val  = ten_over ? ten_lim : ten_mag[47:0];
    assign ten_out  = neg_reg ? (48'd0 - ten_val) : ten_val;

    assign e_over = |acc_reg[191:80];
    assign e_val  = e_over ? mhbf_pkg::MAX63 : acc_reg[79:17];

    // force share of one bead on one axis; a and b pull along +m, c and d along -m
    assign f_bd    = bd_reg[1] ? f2_reg : f1_reg;
    assign w_bd    = bd_reg[0] ? f_bd : (mhbf_pkg::ONE_Q16 - f_bd);
    assign qs      = div_n_reg[127:32];
    assign sh_sign = bd_reg[1] ? ~(neg_reg ^ m_cur[33]) : (neg_reg ^ m_cur[33]);
    assign sh_lim  = sh_sign ? mhbf_pkg::LIM48_NEG : mhbf_pkg::LIM48_POS;
    assign sh_over = (qs > {48'd0, sh_lim});
    assign sh_val  = sh_over ? sh_lim : qs[47:0];
    assign sh_out  = sh_sign ? (48'd0 - sh_val) : sh_val;

    assign lane     = frd_reg[48 * int'(ax_reg) +: 48];
    assign sum49    = {lane[47], lane} + {share_reg[47], share_reg};
    assign acc_ovf  = sum49[48] ^ sum49[47];
    assign new_lane = acc_ovf ? (sum49[48] ? mhbf_pkg::LIM48_NEG : mhbf_pkg::LIM48_POS)
                              : sum49[47:0];

    // shared multiplier: limb product now, shifted accumulate of the last product
    assign a_limb  = mul_a_reg[{cnt_reg[1:0], 5'd0} +: 32];
    assign b_limb  = mul_b_reg[{cnt_reg[2], 5'd0} +: 32];
    assign mul_pc  = cnt_reg[2:0] - 3'd1;
    assign mul_sh  = {1'b0, mul_pc[1:0]} + {2'd0, mul_pc[2]};
    assign acc_add = acc_reg + ({128'd0, prod_reg} << {mul_sh, 5'd0});

    always_comb begin
        state_next   = state_reg;
        ret_next     = ret_reg;
        cnt_next     = cnt_reg;
        for (int i = 0; i < 4; i++) begin
            idx_next[i] = idx_reg[i];
        end
        for (int i = 0; i < 2; i++) begin
            p_lo_next[i] = p_lo_reg[i];
            p_hi_next[i] = p_hi_reg[i];
        end
        for (int i = 0; i < 3; i++) begin
            m_next[i] = m_reg[i];
        end
        f1_next      = f1_reg;
        f2_next      = f2_reg;
        k_next       = k_reg;
        rl_next      = rl_reg;
        coord_next   = coord_reg;
        v1_next      = v1_reg;
        ax_next      = ax_reg;
        bd_next      = bd_reg;
        seg_next     = seg_reg;
        s_next       = s_reg;
        sq_next      = sq_reg;
        rem_next     = rem_reg;
        root_next    = root_reg;
        d_next       = d_reg;
        ad_next      = ad_reg;
        neg_next     = neg_reg;
        sat_next     = sat_reg;
        kd_next      = kd_reg;
        ten_next     = ten_reg;
        e_next       = e_reg;
        num_next     = num_reg;
        div_n_next   = div_n_reg;
        share_next   = share_reg;
        mul_a_next   = mul_a_reg;
        mul_b_next   = mul_b_reg;
        acc_next     = acc_reg;
        done_next    = 1'b0;
        energy_next  = '0;
        tension_next = '0;
        fx_next      = '0;
        fy_next      = '0;
        fz_next      = '0;
        status_next  = mhbf_pkg::STAT_OK;
        go_mul       = 1'b0;
        go_a         = '0;
        go_b         = '0;
        go_ret       = mhbf_pkg::S_IDLE;
        pos_we       = 1'b0;
        force_we     = 1'b0;
        force_wdata  = frd_reg;

        unique case (state_reg)
            mhbf_pkg::S_IDLE: begin
                if (start) begin
                    idx_next[0] = bead_mod(bead_a);
                    idx_next[1] = bead_mod(bead_b);
                    idx_next[2] = bead_mod(bead_c);
                    idx_next[3] = bead_mod(bead_d);
                    f1_next     = (pos_first > mhbf_pkg::ONE_Q16) ? mhbf_pkg::ONE_Q16
                                                                  : pos_first;
                    f2_next     = (pos_second > mhbf_pkg::ONE_Q16) ? mhbf_pkg::ONE_Q16
                                                                   : pos_second;
                    k_next      = stiffness;
                    rl_next     = rest_length;
                    coord_next  = {coord_z, coord_y, coord_x};
                    sat_next    = 1'b0;
                    s_next      = '0;
                    ax_next     = 2'd0;
                    seg_next    = 1'b0;
                    cnt_next    = '0;
                    unique case (req_type)
                        mhbf_pkg::REQ_LOAD: state_next = mhbf_pkg::S_LOAD;
                        mhbf_pkg::REQ_BOND: state_next = mhbf_pkg::S_POS;
                        mhbf_pkg::REQ_READ: state_next = mhbf_pkg::S_FRD;
                        default:            state_next = mhbf_pkg::S_NOP;
                    endcase
                end
            end
            mhbf_pkg::S_NOP: begin
                done_next  = 1'b1;
                state_next = mhbf_pkg::S_IDLE;
            end
            mhbf_pkg::S_LOAD: begin
                pos_we      = 1'b1;
                force_we    = 1'b1;
                force_wdata = '0;
                done_next   = 1'b1;
                state_next  = mhbf_pkg::S_IDLE;
            end
            mhbf_pkg::S_FRD: begin
                state_next = mhbf_pkg::S_FRD_WAIT;
            end
            mhbf_pkg::S_FRD_WAIT: begin
                done_next  = 1'b1;
                fx_next    = frd_reg[47:0];
                fy_next    = frd_reg[95:48];
                fz_next    = frd_reg[143:96];
                state_next = mhbf_pkg::S_IDLE;
            end
            mhbf_pkg::S_POS: begin
                // read data is registered and arrives in the cycle after its address
                unique case (cnt_reg[2:0])
                    3'd1:    p_lo_next[0] = pos_rd_reg;
                    3'd2:    p_hi_next[0] = pos_rd_reg;
                    3'd3:    p_lo_next[1] = pos_rd_reg;
                    3'd4:    p_hi_next[1] = pos_rd_reg;
                    default: ;
                endcase
                if (cnt_reg == 7'd4) begin
                    state_next = mhbf_pkg::S_MID;
                end else begin
                    cnt_next = cnt_reg + 7'd1;
                end
            end
            mhbf_pkg::S_MID: begin
                go_mul = 1'b1;
                go_a   = 128'(diff_mag);
                go_b   = 64'(f_seg);
                go_ret = mhbf_pkg::S_MID_DONE;
            end
            mhbf_pkg::S_MID_DONE: begin
                if (!seg_reg) begin
                    v1_next    = vmid;
                    seg_next   = 1'b1;
                    state_next = mhbf_pkg::S_MID;
                end else begin
                    m_next[ax_reg] = vmid - v1_reg;
                    seg_next       = 1'b0;
                    if (ax_reg == 2'd2) begin
                        ax_next    = 2'd0;
                        state_next = mhbf_pkg::S_SQ;
                    end else begin
                        ax_next    = ax_reg + 2'd1;
                        state_next = mhbf_pkg::S_MID;
                    end
                end
            end
            mhbf_pkg::S_SQ: begin
                go_mul = 1'b1;
                go_a   = 128'(m_abs[32:0]);
                go_b   = 64'(m_abs[32:0]);
                go_ret = mhbf_pkg::S_SQ_DONE;
            end
            mhbf_pkg::S_SQ_DONE: begin
                s_next = s_sum;
                if (ax_reg == 2'd2) begin
                    sq_next    = {6'd0, s_sum};
                    rem_next   = '0;
                    root_next  = '0;
                    cnt_next   = '0;
                    ax_next    = 2'd0;
                    state_next = mhbf_pkg::S_SQRT;
                end else begin
                    ax_next    = ax_reg + 2'd1;
                    state_next = mhbf_pkg::S_SQ;
                end
            end
            mhbf_pkg::S_SQRT: begin
                sq_next = {sq_reg[71:0], 2'b00};
                if (sq_ge) begin
                    rem_next  = rem2 - trial;
                    root_next = {root_reg[35:0], 1'b1};
                end else begin
                    rem_next  = rem2;
                    root_next = {root_reg[35:0], 1'b0};
                end
                if (cnt_reg == 7'd36) begin
                    d_next     = root_next;
                    state_next = mhbf_pkg::S_TEN;
                end else begin
                    cnt_next = cnt_reg + 7'd1;
                end
            end
            mhbf_pkg::S_TEN: begin
                ad_next  = dl_abs[36:0];
                neg_next = dl[37];
                go_mul   = 1'b1;
                go_a     = 128'(dl_abs[36:0]);
                go_b     = 64'(k_reg);
                go_ret   = mhbf_pkg::S_KD_DONE;
            end
            mhbf_pkg::S_KD_DONE: begin
                kd_next  = acc_reg[68:0];
                ten_next = ten_out;
                if (ten_over) begin
                    sat_next = 1'b1;
                end
                go_mul = 1'b1;
                go_a   = 128'(ad_reg);
                go_b   = 64'(ad_reg);
                go_ret = mhbf_pkg::S_E1;
            end
            mhbf_pkg::S_E1: begin
                go_mul = 1'b1;
                go_a   = 128'(acc_reg[73:0]);
                go_b   = 64'(k_reg);
                go_ret = mhbf_pkg::S_E2;
            end
            mhbf_pkg::S_E2: begin
                e_next = e_val;
                if (e_over) begin
                    sat_next = 1'b1;
                end
                ax_next = 2'd0;
                if (d_reg == '0) begin
                    // coincident points: no direction, accumulators untouched
                    done_next    = 1'b1;
                    energy_next  = e_val;
                    tension_next = ten_reg;
                    status_next  = sat_next ? mhbf_pkg::STAT_SAT : mhbf_pkg::STAT_ZERO;
                    state_next   = mhbf_pkg::S_IDLE;
                end else begin
                    state_next = mhbf_pkg::S_NUM;
                end
            end
            mhbf_pkg::S_NUM: begin
                go_mul = 1'b1;
                go_a   = 128'(kd_reg);
                go_b   = 64'(m_abs[32:0]);
                go_ret = mhbf_pkg::S_NUM_DONE;
            end
            mhbf_pkg::S_NUM_DONE: begin
                num_next   = acc_reg[101:0];
                bd_next    = 2'd0;
                state_next = mhbf_pkg::S_W;
            end
            mhbf_pkg::S_W: begin
                go_mul = 1'b1;
                go_a   = 128'(num_reg);
                go_b   = 64'(w_bd);
                go_ret = mhbf_pkg::S_DIV_INIT;
            end
            mhbf_pkg::S_DIV_INIT: begin
                div_n_next = acc_reg[127:0];
                rem_next   = '0;
                cnt_next   = '0;
                state_next = mhbf_pkg::S_DIV;
            end
            mhbf_pkg::S_DIV: begin
                rem_next   = dv_ge ? (drem2 - d39) : drem2;
                div_n_next = {div_n_reg[126:0], dv_ge};
                if (cnt_reg == 7'd127) begin
                    state_next = mhbf_pkg::S_SHARE;
                end else begin
                    cnt_next = cnt_reg + 7'd1;
                end
            end
            mhbf_pkg::S_SHARE: begin
                share_next = sh_out;
                if (sh_over) begin
                    sat_next = 1'b1;
                end
                state_next = mhbf_pkg::S_ACC;
            end
            mhbf_pkg::S_ACC: begin
                force_we                             = 1'b1;
                force_wdata[48 * int'(ax_reg) +: 48] = new_lane;
                if (acc_ovf) begin
                    sat_next = 1'b1;
                end
                if (bd_reg == 2'd3) begin
                    if (ax_reg == 2'd2) begin
                        done_next    = 1'b1;
                        energy_next  = e_reg;
                        tension_next = ten_reg;
                        status_next  = sat_next ? mhbf_pkg::STAT_SAT : mhbf_pkg::STAT_OK;
                        state_next   = mhbf_pkg::S_IDLE;
                    end else begin
                        ax_next    = ax_reg + 2'd1;
                        state_next = mhbf_pkg::S_NUM;
                    end
                end else begin
                    bd_next    = bd_reg + 2'd1;
                    state_next = mhbf_pkg::S_W;
                end
            end
            mhbf_pkg::S_MUL: begin
                if (cnt_reg != 7'd0) begin
                    acc_next = acc_add;
                end
                if (cnt_reg == 7'd8) begin
                    state_next = ret_reg;
                end else begin
                    cnt_next = cnt_reg + 7'd1;
                end
            end
            default: state_next = mhbf_pkg::S_IDLE;
        endcase

        if (go_mul) begin
            mul_a_next = go_a;
            mul_b_next = go_b;
            acc_next   = '0;
            cnt_next   = '0;
            ret_next   = go_ret;
            state_next = mhbf_pkg::S_MUL;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= mhbf_pkg::S_IDLE;
            ret_reg   <= mhbf_pkg::S_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            done_reg  <= done_next;
        end
    end

    // datapath and result payload
    always_ff @(posedge clk) begin
        cnt_reg     <= cnt_next;
        for (int i = 0; i < 4; i++) begin
            idx_reg[i] <= idx_next[i];
        end
        for (int i = 0; i < 2; i++) begin
            p_lo_reg[i] <= p_lo_next[i];
            p_hi_reg[i] <= p_hi_next[i];
        end
        for (int i = 0; i < 3; i++) begin
            m_reg[i] <= m_next[i];
        end
        f1_reg      <= f1_next;
        f2_reg      <= f2_next;
        k_reg       <= k_next;
        rl_reg      <= rl_next;
        coord_reg   <= coord_next;
        v1_reg      <= v1_next;
        ax_reg      <= ax_next;
        bd_reg      <= bd_next;
        seg_reg     <= seg_next;
        s_reg       <= s_next;
        sq_reg      <= sq_next;
        rem_reg     <= rem_next;
        root_reg    <= root_next;
        d_reg       <= d_next;
        ad_reg      <= ad_next;
        neg_reg     <= neg_next;
        sat_reg     <= sat_next;
        kd_reg      <= kd_next;
        ten_reg     <= ten_next;
        e_reg       <= e_next;
        num_reg     <= num_next;
        div_n_reg   <= div_n_next;
        share_reg   <= share_next;
        mul_a_reg   <= mul_a_next;
        mul_b_reg   <= mul_b_next;
        acc_reg     <= acc_next;
        prod_reg    <= a_limb * b_limb;
        energy_reg  <= energy_next;
        tension_reg <= tension_next;
        fx_reg      <= fx_next;
        fy_reg      <= fy_next;
        fz_reg      <= fz_next;
        status_reg  <= status_next;
    end

    // position store
    always_ff @(posedge clk) begin
        if (pos_we) begin
            pos_mem[idx_sel] <= coord_reg;
        end
        pos_rd_reg <= pos_mem[idx_sel];
    end

    // force store, read-modify-write one share at a time so aliased beads add in order
    always_ff @(posedge clk) begin
        if (force_we) begin
            force_mem[idx_sel] <= force_wdata;
        end
        frd_reg <= force_mem[idx_sel];
    end

`ifndef SYNTHESIS
    a_done_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result strobe without work in flight");

    a_accept_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not start work");

    a_force_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
        force_we |-> busy)
        else $error("force store written while idle");

    a_sqrt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mhbf_pkg::S_SQRT) |-> (cnt_reg <= 7'd36))
        else $error("square root ran past its digit count");
`endif

endmodule

[tb/tb_midpoint_harmonic_bond_force.sv]
`timescale 1ns / 1ps

module tb_midpoint_harmonic_bond_force;

    localparam int  NUM_BEADS   = 4096;
    localparam int  RAND_ITEMS  = 1180;
    localparam int  CYCLE_LIMIT = 12_000_000;
    localparam bit [1:0] REQ_NOP = 2'd3;

    typedef struct {
        logic [1:0]         req;
        logic [11:0]        a, b, c, d;
        logic signed [31:0] x, y, z;
        logic [16:0]        f1, f2;
        logic [31:0]        k;
        logic [30:0]        rest;
        bit                 drain;     // hold off until all results are back
    } request_t;

    typedef struct {
        logic [62:0]        energy;
        logic signed [47:0] tension;
        logic signed [47:0] fx, fy, fz;
        logic [1:0]         status;
    } answer_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    // dut inputs, all known from time zero
    logic               start = 1'b0;
    logic [1:0]         req_type = '0;
    logic [11:0]        bead_a = '0, bead_b = '0, bead_c = '0, bead_d = '0;
    logic signed [31:0] coord_x = '0, coord_y = '0, coord_z = '0;
    logic [16:0]        pos_first = '0, pos_second = '0;
    logic [31:0]        stiffness = '0;
    logic [30:0]        rest_length = '0;

    logic               busy, done;
    logic [62:0]        energy;
    logic signed [47:0] tension, force_x, force_y, force_z;
    logic [1:0]         status;

    request_t pending_items[$];
    answer_t  expected_answers[$];
    request_t cur_item;
    int       fail_count = 0;
    int       accepted_count = 0;
    int       cycle_count = 0;

    // predictor copy of the bead store
    logic signed [31:0] bead_pos [0:2][0:NUM_BEADS-1];
    logic signed [47:0] bead_frc [0:2][0:NUM_BEADS-1];

    // generator-side record of which beads have been loaded
    bit gen_loaded [0:NUM_BEADS-1];
    int loaded_list[$];

    always #2 clk = ~clk;

    midpoint_harmonic_bond_force i_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .done(done),
        .req_type(req_type), .bead_a(bead_a), .bead_b(bead_b), .bead_c(bead_c),
        .bead_d(bead_d), .coord_x(coord_x), .coord_y(coord_y), .coord_z(coord_z),
        .pos_first(pos_first), .pos_second(pos_second), .stiffness(stiffness),
        .rest_length(rest_length), .energy(energy), .tension(tension),
        .force_x(force_x), .force_y(force_y), .force_z(force_z), .status(status)
    );

    function automatic longint unsigned magnitude(longint signed v);
        return v < 0 ? longint'(0) - v : v;
    endfunction

    // clamp a magnitude into the signed 48-bit range
    function automatic longint signed clamp48(logic [127:0] m, bit neg, inout bit sat);
        logic [127:0] lim;
        logic [127:0] v;
        lim = neg ? 128'h8000_0000_0000 : 128'h7FFF_FFFF_FFFF;
        v = m;
        if (v > lim) begin
            v = lim;
            sat = 1'b1;
        end
        return neg ? -longint'(v[63:0]) : longint'(v[63:0]);
    endfunction

    // point at fraction f along p1..p2, offset from p1 truncated toward zero
    function automatic longint signed seg_point(longint signed p1, longint signed p2,
                                                longint unsigned f);
        longint signed   diff;
        longint unsigned t;
        diff = p2 - p1;
        t = (magnitude(diff) * f) >> 16;
        return diff < 0 ? p1 - longint'(t) : p1 + longint'(t);
    endfunction

    // bond evaluation: energy, tension and force shares onto the four beads
    function automatic answer_t bond_evaluate(request_t r);
        answer_t         ans;
        longint unsigned f1, f2, w, dlen, ad;
        longint signed   v1, v2, dl, share, acc;
        longint signed   m[3];
        logic [127:0]    sumsq, kd, e, num, q, cand;
        logic [11:0]     idx[4];
        bit              neg, sat, base;
        ans = '{default: '0};
        sat = 1'b0;
        idx[0] = r.a; idx[1] = r.b; idx[2] = r.c; idx[3] = r.d;
        f1 = r.f1 > mhbf_pkg::ONE_Q16 ? mhbf_pkg::ONE_Q16 : r.f1;
        f2 = r.f2 > mhbf_pkg::ONE_Q16 ? mhbf_pkg::ONE_Q16 : r.f2;
        sumsq = '0;
        for (int ax = 0; ax < 3; ax++) begin
            v1 = seg_point(bead_pos[ax][idx[0]], bead_pos[ax][idx[1]], f1);
            v2 = seg_point(bead_pos[ax][idx[2]], bead_pos[ax][idx[3]], f2);
            m[ax] = v2 - v1;
            sumsq += 128'(magnitude(m[ax])) * 128'(magnitude(m[ax]));
        end
        dlen = 0;
        for (int bt = 36; bt >= 0; bt--) begin
            cand = 128'(dlen | (64'd1 << bt));
            if (cand * cand <= sumsq)
                dlen = cand[63:0];
        end
        dl = longint'(dlen) - longint'(r.rest);
        neg = dl < 0;
        ad = magnitude(dl);
        kd = 128'(r.k) * 128'(ad);
        ans.tension = 48'(clamp48(kd >> 16, neg, sat));
        e = (128'(ad) * 128'(ad) * 128'(r.k)) >> 17;
        if (e > 128'(mhbf_pkg::MAX63)) begin
            e = 128'(mhbf_pkg::MAX63);
            sat = 1'b1;
        end
        ans.energy = e[62:0];
        if (dlen != 0) begin
            for (int ax = 0; ax < 3; ax++) begin
                num = kd * 128'(magnitude(m[ax]));
                base = neg != (m[ax] < 0);
                for (int bd = 0; bd < 4; bd++) begin
                    w = (bd & 1) ? (bd < 2 ? f1 : f2)
                                 : mhbf_pkg::ONE_Q16 - (bd < 2 ? f1 : f2);
                    q = ((num * 128'(w)) / 128'(dlen)) >> 32;
                    share = clamp48(q, bd < 2 ? base : !base, sat);
                    acc = longint'(bead_frc[ax][idx[bd]]) + share;
                    if (acc > longint'(mhbf_pkg::LIM48_POS)) begin
                        acc = longint'(mhbf_pkg::LIM48_POS);
                        sat = 1'b1;
                    end
                    if (acc < -longint'(mhbf_pkg::LIM48_POS) - 1) begin
                        acc = -longint'(mhbf_pkg::LIM48_POS) - 1;
                        sat = 1'b1;
                    end
                    bead_frc[ax][idx[bd]] = acc[47:0];
                end
            end
        end
        ans.status = sat ? mhbf_pkg::STAT_SAT
                         : (dlen == 0 ? mhbf_pkg::STAT_ZERO : mhbf_pkg::STAT_OK);
        return ans;
    endfunction

    // apply one accepted item to the predictor and queue its answer
    task automatic predict_item(request_t r);
        answer_t ans;
        ans = '{default: '0};
        case (r.req)
            mhbf_pkg::REQ_LOAD: begin
                bead_pos[0][r.a] = r.x;
                bead_pos[1][r.a] = r.y;
                bead_pos[2][r.a] = r.z;
                for (int ax = 0; ax < 3; ax++)
                    bead_frc[ax][r.a] = '0;
            end
            mhbf_pkg::REQ_READ: begin
                ans.fx = bead_frc[0][r.a];
                ans.fy = bead_frc[1][r.a];
                ans.fz = bead_frc[2][r.a];
            end
            mhbf_pkg::REQ_BOND: ans = bond_evaluate(r);
            default: ;
        endcase
        expected_answers.insert(expected_answers.size(), ans);
    endtask

    // ---------------- stimulus building ----------------

    task automatic queue_item(logic [1:0] rq, int a, int b, int c, int d,
                              logic [31:0] x, logic [31:0] y, logic [31:0] z,
                              logic [16:0] f1, logic [16:0] f2,
                              logic [31:0] k, logic [30:0] rest, bit drain);
        request_t r;
        r.req = rq; r.a = 12'(a); r.b = 12'(b); r.c = 12'(c); r.d = 12'(d);
        r.x = x; r.y = y; r.z = z;
        r.f1 = f1; r.f2 = f2; r.k = k; r.rest = rest; r.drain = drain;
        if (rq == mhbf_pkg::REQ_LOAD && !gen_loaded[a]) begin
            gen_loaded[a] = 1'b1;
            loaded_list.insert(loaded_list.size(), a);
        end
        pending_items.insert(pending_items.size(), r);
    endtask

    function automatic int pick_loaded();
        return loaded_list[$urandom_range(loaded_list.size() - 1)];
    endfunction

    // coordinates mostly in a working range so bonds stay out of saturation
    function automatic logic [31:0] rand_coord();
        int sel;
        sel = $urandom_range(9);
        if (sel < 6)
            return 32'($signed($urandom_range(2 * 2 ** 22)) - 2 ** 22);
        else if (sel == 6)
            return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
        return $urandom;
    endfunction

    function automatic logic [16:0] rand_fraction();
        int sel;
        sel = $urandom_range(9);
        if (sel == 0) return 17'd0;
        if (sel == 1) return mhbf_pkg::ONE_Q16;
        if (sel == 2) return 17'($urandom_range(131071));
        return 17'($urandom_range(65536));
    endfunction

    function automatic logic [31:0] rand_stiffness();
        int sel;
        sel = $urandom_range(9);
        if (sel == 0) return 32'd0;
        if (sel == 1) return 32'hFFFF_FFFF;
        if (sel < 4) return $urandom;
        return 32'($urandom_range(2 ** 22));
    endfunction

    function automatic logic [30:0] rand_rest();
        int sel;
        sel = $urandom_range(9);
        if (sel == 0) return 31'd0;
        if (sel == 1) return 31'h7FFF_FFFF;
        if (sel < 4) return 31'($urandom);
        return 31'($urandom_range(2 ** 24));
    endfunction

    task automatic build_directed();
        // corner beads and extreme coordinates
        queue_item(mhbf_pkg::REQ_LOAD, 0, 0, 0, 0, 32'h0, 32'h0, 32'h0, 0, 0, 0, 0, 0);
        queue_item(mhbf_pkg::REQ_LOAD, 4095, 0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000,
                   32'h7FFF_FFFF, 0, 0, 0, 0, 0);
        queue_item(mhbf_pkg::REQ_LOAD, 1, 0, 0, 0, 32'h0001_0000, 32'h0002_0000,
                   32'hFFFF_0000, 0, 0, 0, 0, 0);
        queue_item(mhbf_pkg::REQ_LOAD, 2, 0, 0, 0, 32'h0004_0000, 32'h0000_0000,
                   32'h0003_0000, 0, 0, 0, 0, 0);
        queue_item(mhbf_pkg::REQ_LOAD, 2048, 0, 0, 0, 32'h8000_0000, 32'h7FFF_FFFF,
                   32'h8000_0000, 0, 0, 0, 0, 0);
        // plain bond, fractions at the ends of the segments
        queue_item(mhbf_pkg::REQ_BOND, 0, 1, 2, 1, 0, 0, 0, 17'd0, mhbf_pkg::ONE_Q16,
                   32'h0001_0000, 31'h0000_8000, 0);
        // fractions above one saturate
        queue_item(mhbf_pkg::REQ_BOND, 0, 1, 1, 2, 0, 0, 0, 17'h1_FFFF, 17'h1_8000,
                   32'h0002_0000, 31'h0004_0000, 0);
        // zero distance: both points on the same bead
        queue_item(mhbf_pkg::REQ_BOND, 1, 1, 1, 1, 0, 0, 0, 17'h0_8000, 17'h0_4000,
                   32'h0003_0000, 31'h0001_0000, 0);
        // zero stiffness and zero rest length
        queue_item(mhbf_pkg::REQ_BOND, 0, 2, 1, 2, 0, 0, 0, 17'h0_8000, 17'h0_8000, 32'h0,
                   31'h0, 0);
        // aliased beads, a equal to c
        queue_item(mhbf_pkg::REQ_BOND, 1, 2, 1, 0, 0, 0, 0, 17'h0_3000, 17'h0_C000,
                   32'h0001_8000, 31'h0000_1000, 0);
        // huge distance and stiffness: everything saturates
        queue_item(mhbf_pkg::REQ_BOND, 4095, 0, 2048, 0, 0, 0, 0, 17'd0, 17'd0,
                   32'hFFFF_FFFF, 31'h0, 0);
        queue_item(mhbf_pkg::REQ_BOND, 4095, 0, 2048, 0, 0, 0, 0, 17'd0, 17'd0,
                   32'hFFFF_FFFF, 31'h7FFF_FFFF, 0);
        queue_item(mhbf_pkg::REQ_BOND, 4095, 2048, 0, 1, 0, 0, 0, 17'd0, 17'd0,
                   32'hFFFF_FFFF, 31'h7FFF_FFFF, 0);
        queue_item(mhbf_pkg::REQ_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        queue_item(mhbf_pkg::REQ_READ, 4095, 4095, 4095, 4095, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                   32'hFFFF_FFFF, 17'h1_FFFF, 17'h1_FFFF, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 0);
        queue_item(mhbf_pkg::REQ_READ, 2048, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        queue_item(mhbf_pkg::REQ_READ, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        queue_item(REQ_NOP, 4095, 4095, 4095, 4095, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                   32'hFFFF_FFFF, 17'h1_FFFF, 17'h1_FFFF, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 0);
        // reload clears the accumulated force
        queue_item(mhbf_pkg::REQ_LOAD, 4095, 0, 0, 0, 32'h0, 32'h0, 32'h0, 0, 0, 0, 0, 1);
        queue_item(mhbf_pkg::REQ_READ, 4095, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    endtask

    task automatic build_random();
        int sel;
        for (int n = 0; n < RAND_ITEMS; n++) begin
            sel = $urandom_range(99);
            // occasional full drain before the next item
            if (sel < 30 || loaded_list.size() < 4)
                queue_item(mhbf_pkg::REQ_LOAD, $urandom_range(NUM_BEADS - 1),
                           $urandom_range(4095), $urandom_range(4095), $urandom_range(4095),
                           rand_coord(), rand_coord(), rand_coord(), 17'($urandom),
                           17'($urandom), $urandom, 31'($urandom), n % 200 == 199);
            else if (sel < 55)
                queue_item(mhbf_pkg::REQ_BOND, pick_loaded(), pick_loaded(), pick_loaded(),
                           pick_loaded(), $urandom, $urandom, $urandom, rand_fraction(),
                           rand_fraction(), rand_stiffness(), rand_rest(), n % 200 == 199);
            else if (sel < 92)
                queue_item(mhbf_pkg::REQ_READ, pick_loaded(), $urandom_range(4095),
                           $urandom_range(4095), $urandom_range(4095), $urandom, $urandom,
                           $urandom, 17'($urandom), 17'($urandom), $urandom, 31'($urandom),
                           n % 200 == 199);
            else
                queue_item(REQ_NOP, $urandom_range(4095), $urandom_range(4095),
                           $urandom_range(4095), $urandom_range(4095), $urandom, $urandom,
                           $urandom, 17'($urandom), 17'($urandom), $urandom, 31'($urandom),
                           n % 200 == 199);
        end
    endtask

    // ---------------- driver ----------------

    // no idling for a long run of items in the middle
    function automatic bit idle_now();
        if (accepted_count >= 400 && accepted_count < 600)
            return 1'b0;
        return $urandom_range(99) < 15;
    endfunction

    always @(posedge clk) begin
        if (rst_n) begin
            // accepting edge: start high and busy low
            if (start && !busy) begin
                predict_item(cur_item);
                accepted_count++;
            end
            if (!start || !busy) begin
                if (pending_items.size() > 0 && !idle_now() &&
                    !(pending_items[0].drain && expected_answers.size() > 0)) begin
                    cur_item = pending_items.pop_front();
                    start       <= 1'b1;
                    req_type    <= cur_item.req;
                    bead_a      <= cur_item.a;
                    bead_b      <= cur_item.b;
                    bead_c      <= cur_item.c;
                    bead_d      <= cur_item.d;
                    coord_x     <= cur_item.x;
                    coord_y     <= cur_item.y;
                    coord_z     <= cur_item.z;
                    pos_first   <= cur_item.f1;
                    pos_second  <= cur_item.f2;
                    stiffness   <= cur_item.k;
                    rest_length <= cur_item.rest;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // ---------------- monitor ----------------

    always @(posedge clk) begin
        answer_t exp_ans;
        if (rst_n && done) begin
            if (expected_answers.size() == 0) begin
                $display("%0t: result with no item outstanding", $time);
                fail_count++;
            end else begin
                exp_ans = expected_answers.pop_front();
                if (energy !== exp_ans.energy) begin
                    $display("%0t: energy expected %h actual %h", $time, exp_ans.energy, energy);
                    fail_count++;
                end
                if (tension !== exp_ans.tension) begin
                    $display("%0t: tension expected %h actual %h", $time, exp_ans.tension,
                             tension);
                    fail_count++;
                end
                if (force_x !== exp_ans.fx) begin
                    $display("%0t: force_x expected %h actual %h", $time, exp_ans.fx, force_x);
                    fail_count++;
                end
                if (force_y !== exp_ans.fy) begin
                    $display("%0t: force_y expected %h actual %h", $time, exp_ans.fy, force_y);
                    fail_count++;
                end
                if (force_z !== exp_ans.fz) begin
                    $display("%0t: force_z expected %h actual %h", $time, exp_ans.fz, force_z);
                    fail_count++;
                end
                if (status !== exp_ans.status) begin
                    $display("%0t: status expected %h actual %h", $time, exp_ans.status,
                             status);
                    fail_count++;
                end
            end
        end
    end

    // ---------------- watchdog ----------------

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ---------------- sequence ----------------

    initial begin
        for (int i = 0; i < NUM_BEADS; i++) begin
            gen_loaded[i] = 1'b0;
            for (int ax = 0; ax < 3; ax++) begin
                bead_pos[ax][i] = '0;
                bead_frc[ax][i] = '0;
            end
        end
        build_directed();
        build_random();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        do
            @(posedge clk);
        while (pending_items.size() > 0 || start || expected_answers.size() > 0);
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
